// ----- rtl/cla_pkg.sv -----
// Shared types and constants for the command line assembler.
`default_nettype none

package cla_pkg;

	// Request codes
	localparam logic [1:0] REQ_RX         = 2'd0;
	localparam logic [1:0] REQ_READ       = 2'd1;
	localparam logic [1:0] REQ_RELEASE    = 2'd2;
	localparam logic [1:0] REQ_LINE_RESET = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_MSG    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Held message types
	localparam logic [1:0] MSG_NONE   = 2'd0;
	localparam logic [1:0] MSG_USER   = 2'd1;
	localparam logic [1:0] MSG_MODBUS = 2'd2;

	// Character codes
	localparam logic [7:0] CH_CASE_MASK = 8'hDF;
	localparam logic [7:0] CH_COLON     = 8'h3A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_PROMPT    = 8'h3E;
	localparam logic [7:0] CH_BS        = 8'h08;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_QUERY     = 8'h3F;
	localparam logic [7:0] CH_DIGIT_LO  = 8'h30;
	localparam logic [7:0] CH_DIGIT_HI  = 8'h39;
	localparam logic [7:0] CH_UPPER_LO  = 8'h41;
	localparam logic [7:0] CH_UPPER_HI  = 8'h5A;
	localparam logic [7:0] CH_LOWER_LO  = 8'h61;
	localparam logic [7:0] CH_LOWER_HI  = 8'h7A;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
		logic [4:0] read_index;
	} req_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] tx_byte;
		logic [7:0] msg_byte;
		logic [1:0] msg_type;
		logic [4:0] msg_length;
		logic       refused;
		logic       last;
	} res_t;

	// Work handed from the front end to the back end
	typedef enum logic [2:0] {
		JOB_STATUS,
		JOB_TX,
		JOB_BS,
		JOB_WRAP,
		JOB_READ
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] byte_val;
		logic [4:0] pos;
		logic       echo;
		logic       copy;
		logic       hit;
		logic [1:0] msg_type;
		logic [4:0] msg_length;
		logic       refused;
	} job_t;

endpackage

`default_nettype wire

// ----- rtl/cla_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module cla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/cla_front.sv -----
// Front end: accepts requests, classifies bytes and keeps the line state.
`default_nettype none

module cla_front import cla_pkg::*; #(
	parameter int LINE_DEPTH = 32,
	localparam int AW = $clog2(LINE_DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire req_t          req,
	output logic               job_push,
	output job_t               job,
	input  wire logic          jq_full,
	input  wire logic          wrap_done,
	output logic               line_we,
	output logic [AW-1:0]      line_waddr,
	output logic [7:0]         line_wdata
);

	localparam logic [AW-1:0] MAX_CNT = AW'(LINE_DEPTH - 1);

	logic [AW-1:0] char_count_q, count_d;
	logic          cr_pending_q, cr_d;
	logic          colon_seen_q, colon_d;
	logic          first_colon_q, first_colon_d;
	logic [1:0]    held_type_q, held_type_d;
	logic [AW-1:0] held_length_q, held_length_d;
	logic          wrap_busy_q;

	logic       accept;
	logic       is_lower, is_upper, is_digit, keep, can_store, do_wrap;
	logic [7:0] up_byte;
	job_t       job_d;

	// Hold off while the job queue is full or a line sweep is in flight
	assign full   = jq_full || wrap_busy_q;
	assign accept = push && !full;

	// Classify the request and work out the next line state
	always_comb begin
		is_lower  = (req.rx_byte >= CH_LOWER_LO) && (req.rx_byte <= CH_LOWER_HI);
		is_upper  = (req.rx_byte >= CH_UPPER_LO) && (req.rx_byte <= CH_UPPER_HI);
		is_digit  = (req.rx_byte >= CH_DIGIT_LO) && (req.rx_byte <= CH_DIGIT_HI);
		up_byte   = is_lower ? (req.rx_byte & CH_CASE_MASK) : req.rx_byte;
		keep      = is_lower || is_upper || is_digit || (req.rx_byte == CH_QUERY);
		can_store = char_count_q < MAX_CNT;

		count_d       = char_count_q;
		cr_d          = cr_pending_q;
		colon_d       = colon_seen_q;
		held_type_d   = held_type_q;
		held_length_d = held_length_q;
		do_wrap       = 1'b0;
		line_we       = 1'b0;
		line_waddr    = char_count_q;
		line_wdata    = up_byte;

		job_d = '{kind: JOB_STATUS, byte_val: 8'd0, pos: 5'd0, echo: 1'b0, copy: 1'b0,
			hit: 1'b0, msg_type: MSG_NONE, msg_length: 5'd0, refused: 1'b0};

		if (accept) begin
			case (req.req_type)
				REQ_RX: begin
					if (held_type_q != MSG_NONE) begin
						job_d.refused = 1'b1;
					end else if (req.rx_byte == CH_COLON) begin
						cr_d    = 1'b0;
						colon_d = 1'b1;
						if (can_store) begin
							line_we = 1'b1;
							count_d = char_count_q + 1'b1;
						end
					end else if (keep) begin
						cr_d = 1'b0;
						if (can_store) begin
							line_we = 1'b1;
							count_d = char_count_q + 1'b1;
							if (!colon_seen_q) begin
								job_d.kind     = JOB_TX;
								job_d.byte_val = up_byte;
							end
						end
					end else if (req.rx_byte == CH_BS) begin
						cr_d = 1'b0;
						if (char_count_q != '0) begin
							count_d = char_count_q - 1'b1;
							if (!colon_seen_q) begin
								job_d.kind = JOB_BS;
							end
						end
					end else if (req.rx_byte == CH_LF) begin
						if (cr_pending_q) begin
							cr_d = 1'b0;
						end else begin
							do_wrap = 1'b1;
						end
					end else if (req.rx_byte == CH_CR) begin
						cr_d    = 1'b1;
						do_wrap = 1'b1;
					end
				end
				REQ_READ: begin
					job_d.kind = JOB_READ;
					job_d.pos  = req.read_index;
					job_d.hit  = (held_type_q != MSG_NONE) &&
						(req.read_index < 5'(held_length_q));
				end
				REQ_RELEASE: begin
					held_type_d   = MSG_NONE;
					held_length_d = '0;
				end
				REQ_LINE_RESET: begin
					count_d    = '0;
					job_d.kind = JOB_WRAP;
				end
				default: begin
				end
			endcase
		end

		// Wrap the line up: latch it if non-empty, echo it if a colon muted it
		if (do_wrap) begin
			job_d.kind = JOB_WRAP;
			job_d.pos  = 5'(char_count_q);
			job_d.echo = colon_seen_q;
			job_d.copy = char_count_q != '0;
			if (char_count_q != '0) begin
				held_type_d   = first_colon_q ? MSG_MODBUS : MSG_USER;
				held_length_d = char_count_q;
			end
			count_d = '0;
			colon_d = 1'b0;
		end

		// Track whether the first stored character is a colon
		first_colon_d = first_colon_q;
		if (line_we && (char_count_q == '0)) begin
			first_colon_d = up_byte == CH_COLON;
		end

		job_d.msg_type   = held_type_d;
		job_d.msg_length = 5'(held_length_d);
	end

	assign job_push = accept;
	assign job      = job_d;

	// Line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q  <= '0;
			cr_pending_q  <= 1'b0;
			colon_seen_q  <= 1'b0;
			first_colon_q <= 1'b0;
			held_type_q   <= MSG_NONE;
			held_length_q <= '0;
			wrap_busy_q   <= 1'b0;
		end else begin
			char_count_q  <= count_d;
			cr_pending_q  <= cr_d;
			colon_seen_q  <= colon_d;
			first_colon_q <= first_colon_d;
			held_type_q   <= held_type_d;
			held_length_q <= held_length_d;
			if (accept && (job_d.kind == JOB_WRAP)) begin
				wrap_busy_q <= 1'b1;
			end else if (wrap_done) begin
				wrap_busy_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/cla_job_fifo.sv -----
// Two-entry queue of jobs between the front end and the back end.
`default_nettype none

module cla_job_fifo import cla_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t din,
	output logic      full,
	input  wire logic pop,
	output job_t      dout,
	output logic      empty
);

	job_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/cla_back.sv -----
// Back end: carries out jobs, sweeps the line store and drives the result register.
`default_nettype none

module cla_back import cla_pkg::*; #(
	parameter int LINE_DEPTH = 32,
	localparam int AW = $clog2(LINE_DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_empty,
	input  wire job_t          job,
	output logic               job_pop,
	output logic               wrap_done,
	output logic               line_re,
	output logic [AW-1:0]      line_raddr,
	input  wire logic [7:0]    line_rdata,
	output logic               msg_we,
	output logic [AW-1:0]      msg_waddr,
	output logic [7:0]         msg_wdata,
	output logic               msg_re,
	output logic [AW-1:0]      msg_raddr,
	input  wire logic [7:0]    msg_rdata,
	output logic               empty,
	input  wire logic          pop,
	output res_t               res
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_EMIT   = 7'b0000010,
		ST_SWP_RD = 7'b0000100,
		ST_SWP_WR = 7'b0001000,
		ST_TAIL   = 7'b0010000,
		ST_RD     = 7'b0100000,
		ST_RD_WR  = 7'b1000000
	} state_t;

	state_t        state_q, state_d;
	job_t          cur_q;
	logic [1:0]    step_q, step_d;
	logic [AW-1:0] idx_q, idx_d;
	res_t          out_q, item;
	logic          out_valid_q;
	logic          space, emit;

	assign space = !out_valid_q || pop;
	assign empty = !out_valid_q;
	assign res   = out_q;

	// Sequence the job and build the next result item
	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		idx_d      = idx_q;
		job_pop    = 1'b0;
		wrap_done  = 1'b0;
		line_re    = 1'b0;
		line_raddr = idx_q;
		msg_we     = 1'b0;
		msg_waddr  = idx_q;
		msg_wdata  = line_rdata;
		msg_re     = 1'b0;
		msg_raddr  = cur_q.pos[AW-1:0];
		emit       = 1'b0;
		item       = '{out_kind: KIND_TX, tx_byte: 8'd0, msg_byte: 8'd0,
			msg_type: cur_q.msg_type, msg_length: cur_q.msg_length,
			refused: cur_q.refused, last: 1'b0};

		case (state_q)
			ST_IDLE: begin
				if (!job_empty) begin
					job_pop = 1'b1;
					step_d  = 2'd0;
					idx_d   = '0;
					if (job.kind == JOB_WRAP) begin
						if ((job.pos != 5'd0) && (job.echo || job.copy)) begin
							state_d = ST_SWP_RD;
						end else begin
							state_d = ST_TAIL;
						end
					end else if (job.kind == JOB_READ) begin
						state_d = ST_RD;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (cur_q.kind == JOB_TX) begin
					item.tx_byte = cur_q.byte_val;
					item.last    = 1'b1;
				end else if (cur_q.kind == JOB_BS) begin
					item.tx_byte = (step_q == 2'd1) ? CH_SPACE : CH_BS;
					item.last    = step_q == 2'd2;
				end else begin
					item.out_kind = KIND_STATUS;
					item.last     = 1'b1;
				end
				if (space) begin
					emit   = 1'b1;
					step_d = step_q + 2'd1;
					if (item.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SWP_RD: begin
				line_re = 1'b1;
				state_d = ST_SWP_WR;
			end
			ST_SWP_WR: begin
				// Copy one character and echo it when the line was muted
				item.tx_byte = line_rdata;
				if (space || !cur_q.echo) begin
					msg_we = cur_q.copy;
					emit   = cur_q.echo;
					idx_d  = idx_q + 1'b1;
					if (idx_d == cur_q.pos[AW-1:0]) begin
						state_d = ST_TAIL;
					end else begin
						state_d = ST_SWP_RD;
					end
				end
			end
			ST_TAIL: begin
				case (step_q)
					2'd0:    item.tx_byte = CH_CR;
					2'd1:    item.tx_byte = CH_LF;
					default: item.tx_byte = CH_PROMPT;
				endcase
				item.last = step_q == 2'd2;
				if (space) begin
					emit   = 1'b1;
					step_d = step_q + 2'd1;
					if (item.last) begin
						wrap_done = 1'b1;
						state_d   = ST_IDLE;
					end
				end
			end
			ST_RD: begin
				msg_re  = 1'b1;
				state_d = ST_RD_WR;
			end
			ST_RD_WR: begin
				item.out_kind = KIND_MSG;
				item.msg_byte = cur_q.hit ? msg_rdata : 8'd0;
				item.last     = 1'b1;
				if (space) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= 2'd0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			idx_q   <= idx_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Latch the current job and the result item
	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_q <= job;
		end
		if (emit) begin
			out_q <= item;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/command_line_assembler.sv -----
// Top level of the command line assembler.
//
//   channel   | handshake           | payload
//   ----------+---------------------+-----------------------------------------
//   request   | push / full         | req : req_type, rx_byte, read_index
//   result    | pop / empty         | res : out_kind, tx_byte, msg_byte,
//             |                     |       msg_type, msg_length, refused, last
//
// A request that yields one item passes through the job queue, the back-end
// current-job register and the result register; a message read adds the
// registered read of the message RAM. A wrap-up pops the job, sweeps each line
// character via the registered line RAM read, then emits CR, LF and the prompt.
// The front end holds full high while a wrap-up sweep is in flight.
// Line and message RAMs need no clearing pass; stalls on pop back up through
// the result register and the two-entry job queue to full.
`default_nettype none

module command_line_assembler import cla_pkg::*; #(
	parameter int LINE_DEPTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      full,
	input  wire req_t req,
	output logic      empty,
	input  wire logic pop,
	output res_t      res
);

	localparam int AW = $clog2(LINE_DEPTH);

	logic          job_push, jq_full, jq_pop, jq_empty, wrap_done;
	job_t          job_in, job_out;
	logic          line_we, line_re, msg_we, msg_re;
	logic [AW-1:0] line_waddr, line_raddr, msg_waddr, msg_raddr;
	logic [7:0]    line_wdata, line_rdata, msg_wdata, msg_rdata;

	cla_front #(.LINE_DEPTH(LINE_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req        (req),
		.job_push   (job_push),
		.job        (job_in),
		.jq_full    (jq_full),
		.wrap_done  (wrap_done),
		.line_we    (line_we),
		.line_waddr (line_waddr),
		.line_wdata (line_wdata)
	);

	cla_job_fifo u_jq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (jq_full),
		.pop    (jq_pop),
		.dout   (job_out),
		.empty  (jq_empty)
	);

	cla_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line_ram (
		.clk   (clk),
		.we    (line_we),
		.waddr (line_waddr),
		.wdata (line_wdata),
		.re    (line_re),
		.raddr (line_raddr),
		.rdata (line_rdata)
	);

	cla_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_msg_ram (
		.clk   (clk),
		.we    (msg_we),
		.waddr (msg_waddr),
		.wdata (msg_wdata),
		.re    (msg_re),
		.raddr (msg_raddr),
		.rdata (msg_rdata)
	);

	cla_back #(.LINE_DEPTH(LINE_DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_empty  (jq_empty),
		.job        (job_out),
		.job_pop    (jq_pop),
		.wrap_done  (wrap_done),
		.line_re    (line_re),
		.line_raddr (line_raddr),
		.line_rdata (line_rdata),
		.msg_we     (msg_we),
		.msg_waddr  (msg_waddr),
		.msg_wdata  (msg_wdata),
		.msg_re     (msg_re),
		.msg_raddr  (msg_raddr),
		.msg_rdata  (msg_rdata),
		.empty      (empty),
		.pop        (pop),
		.res        (res)
	);

endmodule

`default_nettype wire

// ----- rtl/cla_checker.sv -----
// Port-level checks on the command line assembler, bound to the top level.
`default_nettype none

module cla_checker import cla_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic empty,
	input wire logic pop,
	input wire res_t res
);

	// A waiting result holds while it is not taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(res)))
		else $error("result changed while stalled");

	// A refused byte yields a single status item
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.refused) |-> (res.out_kind == KIND_STATUS && res.last))
		else $error("refused request did not give a lone status item");

	// A message read yields a single item with no transmit byte
	a_read: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.out_kind == KIND_MSG) |-> (res.last && res.tx_byte == 8'd0))
		else $error("message read item malformed");

	// No held message means no length
	a_none_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.msg_type == MSG_NONE) |-> (res.msg_length == 5'd0))
		else $error("length reported with no message held");

endmodule

bind command_line_assembler cla_checker u_cla_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.res    (res)
);

`default_nettype wire
